// ===== rtl/core/ewt_pkg.sv =====
// ----------------------------------------------------------------------------
// ewt_pkg
// Shared types and constants of the due-date ordering and weighted tardiness
// core.
// ----------------------------------------------------------------------------
package ewt_pkg;

  localparam int MAX_TASKS = 32;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int PROC_W    = 16;
  localparam int WEIGHT_W  = 8;
  localparam int DUE_W     = 20;
  localparam int INDEX_W   = 6;
  localparam int FINISH_W  = 23;
  localparam int PROD_W    = FINISH_W + WEIGHT_W;
  localparam int SUM_W     = 40;

  typedef struct packed {
    logic [PROC_W-1:0]   proc_time;
    logic [WEIGHT_W-1:0] weight;
    logic [DUE_W-1:0]    due_date;
  } task_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_STORE = 8'b0000_0010,
    ST_LATE  = 8'b0000_0100,
    ST_ADD   = 8'b0000_1000,
    ST_SCAN  = 8'b0001_0000,
    ST_TAKE  = 8'b0010_0000,
    ST_MUL   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/core/ewt_in_if.sv =====
// ----------------------------------------------------------------------------
// ewt_in_if
// Task channel: one item carries one task of the set.
// ----------------------------------------------------------------------------
interface ewt_in_if;
  logic                          valid;
  logic                          ready;
  logic [ewt_pkg::PROC_W-1:0]    proc_time;
  logic [ewt_pkg::WEIGHT_W-1:0]  weight;
  logic [ewt_pkg::DUE_W-1:0]     due_date;
  logic                          last_task;

  modport source (output valid, proc_time, weight, due_date, last_task, input ready);
  modport sink   (input valid, proc_time, weight, due_date, last_task, output ready);
endinterface

// ===== rtl/core/ewt_out_if.sv =====
// ----------------------------------------------------------------------------
// ewt_out_if
// Result channel: one item carries one task index of the due-date order.
// ----------------------------------------------------------------------------
interface ewt_out_if;
  logic                          valid;
  logic                          ready;
  logic [ewt_pkg::INDEX_W-1:0]   task_index;
  logic                          end_of_order;
  logic [ewt_pkg::SUM_W-1:0]     edd_penalty;
  logic [ewt_pkg::SUM_W-1:0]     load_order_penalty;

  modport source (output valid, task_index, end_of_order, edd_penalty,
                  load_order_penalty, input ready);
  modport sink   (input valid, task_index, end_of_order, edd_penalty,
                  load_order_penalty, output ready);
endinterface

// ===== rtl/core/ewt_late_mul.sv =====
// ----------------------------------------------------------------------------
// ewt_late_mul
// Registered weighted lateness: max(0, finish - due) times weight.
// ----------------------------------------------------------------------------
module ewt_late_mul (
  input  logic                          clk,
  input  logic [ewt_pkg::FINISH_W-1:0]  finish,
  input  logic [ewt_pkg::DUE_W-1:0]     due_date,
  input  logic [ewt_pkg::WEIGHT_W-1:0]  weight,
  output logic [ewt_pkg::PROD_W-1:0]    prod
);

  logic [ewt_pkg::FINISH_W-1:0] due_ext;
  logic [ewt_pkg::FINISH_W-1:0] late;
  logic [ewt_pkg::PROD_W-1:0]   prod_r;

  assign due_ext = ewt_pkg::FINISH_W'(due_date);
  assign late    = (finish > due_ext) ? (finish - due_ext) : '0;

  always_ff @(posedge clk) begin
    prod_r <= ewt_pkg::PROD_W'(late) * ewt_pkg::PROD_W'(weight);
  end

  assign prod = prod_r;

endmodule

// ===== rtl/core/edd_weighted_tardiness_core.sv =====
// ----------------------------------------------------------------------------
// edd_weighted_tardiness_core
// Stores a set of tasks, sums the weighted tardiness of the load order, then
// emits the task indices in earliest-due-date order with both penalties.
// ----------------------------------------------------------------------------
// Each input item carries one task; the item with last_task set closes the
// set. Up to 32 tasks are kept in a task memory with one write and one read
// port; further tasks are dropped, though a dropped closing item still closes
// the set. A task item passes through the states STORE, LATE and ADD; ADD
// takes the product of the lateness multiplier, which the due-date pass
// shares. No new item is taken until the block is back in IDLE. After the
// closing item the block emits one result item per stored task. Each
// result needs one scan of the task memory, which is read through a
// register. The final result carries end_of_order and both penalties;
// earlier results carry zero penalties.
// The result register holds an item until the receiver takes it; the scan
// for the next index proceeds meanwhile, and after the final result is
// registered the block accepts the next set at once. Synchronous reset
// clears the set, both sums and the valid flag of the result register; the
// task memory needs no clearing because only stored entries are read.
// ----------------------------------------------------------------------------
module edd_weighted_tardiness_core (
  input  logic       clk,
  input  logic       rst_n,
  ewt_in_if.sink     in_chan,
  ewt_out_if.source  out_chan
);

  ewt_pkg::state_t                 state_r, state_nxt;
  ewt_pkg::task_t                  mem [ewt_pkg::MAX_TASKS];
  ewt_pkg::task_t                  rd_data_r;
  ewt_pkg::task_t                  item_r;
  logic                            last_r;
  logic                            stored_r, stored_nxt;

  logic [ewt_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [ewt_pkg::CNT_W-1:0]       emit_cnt_r, emit_cnt_nxt;
  logic [ewt_pkg::CNT_W-1:0]       scan_addr_r, scan_addr_nxt;
  logic                            rd_valid_r, rd_valid_nxt;
  logic [ewt_pkg::IDX_W-1:0]       rd_idx_r;
  logic [ewt_pkg::MAX_TASKS-1:0]   taken_r, taken_nxt;

  logic                            found_r, found_nxt;
  logic [ewt_pkg::IDX_W-1:0]       best_idx_r, best_idx_nxt;
  ewt_pkg::task_t                  best_r, best_nxt;

  logic [ewt_pkg::FINISH_W-1:0]    completion_r, completion_nxt;
  logic [ewt_pkg::FINISH_W-1:0]    finish_r, finish_nxt;
  logic [ewt_pkg::SUM_W-1:0]       load_sum_r, load_sum_nxt;
  logic [ewt_pkg::SUM_W-1:0]       edd_sum_r, edd_sum_nxt;
  logic                            edd_add_r, edd_add_nxt;
  logic [ewt_pkg::SUM_W-1:0]       edd_total;

  logic                            out_valid_r, out_valid_nxt;
  logic [ewt_pkg::INDEX_W-1:0]     out_index_r;
  logic                            out_end_r;
  logic [ewt_pkg::SUM_W-1:0]       out_edd_r;
  logic [ewt_pkg::SUM_W-1:0]       out_load_r;

  logic [ewt_pkg::FINISH_W-1:0]    mul_finish;
  logic [ewt_pkg::DUE_W-1:0]       mul_due;
  logic [ewt_pkg::WEIGHT_W-1:0]    mul_weight;
  logic [ewt_pkg::PROD_W-1:0]      mul_prod;

  logic                            in_fire;
  logic                            issue;
  logic                            out_free;
  logic                            final_emit;
  logic                            load_out;

  assign in_chan.ready = (state_r == ewt_pkg::ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign issue         = (scan_addr_r < count_r);
  assign out_free      = !out_valid_r || out_chan.ready;
  assign final_emit    = ((emit_cnt_r + 1'b1) == count_r);
  assign load_out      = (state_r == ewt_pkg::ST_EMIT) && out_free;
  assign edd_total     = edd_add_r ? (edd_sum_r + ewt_pkg::SUM_W'(mul_prod)) : edd_sum_r;

  always_comb begin
    if (state_r == ewt_pkg::ST_LATE) begin
      mul_finish = completion_r;
      mul_due    = item_r.due_date;
      mul_weight = stored_r ? item_r.weight : '0;
    end else begin
      mul_finish = finish_r;
      mul_due    = best_r.due_date;
      mul_weight = best_r.weight;
    end
  end

  ewt_late_mul u_late_mul (
    .clk      (clk),
    .finish   (mul_finish),
    .due_date (mul_due),
    .weight   (mul_weight),
    .prod     (mul_prod)
  );

  always_comb begin
    state_nxt      = state_r;
    stored_nxt     = stored_r;
    count_nxt      = count_r;
    emit_cnt_nxt   = emit_cnt_r;
    scan_addr_nxt  = scan_addr_r;
    rd_valid_nxt   = 1'b0;
    taken_nxt      = taken_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    completion_nxt = completion_r;
    finish_nxt     = finish_r;
    load_sum_nxt   = load_sum_r;
    edd_sum_nxt    = edd_sum_r;
    edd_add_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    // The product of the previous cycle lands in the due-date sum here.
    if (edd_add_r) begin
      edd_sum_nxt = edd_total;
    end

    unique case (state_r)
      ewt_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ewt_pkg::ST_STORE;
        end
      end
      ewt_pkg::ST_STORE: begin
        stored_nxt = (count_r < ewt_pkg::CNT_W'(ewt_pkg::MAX_TASKS));
        if (stored_nxt) begin
          count_nxt      = count_r + 1'b1;
          completion_nxt = completion_r + ewt_pkg::FINISH_W'(item_r.proc_time);
        end
        state_nxt = ewt_pkg::ST_LATE;
      end
      ewt_pkg::ST_LATE: begin
        state_nxt = ewt_pkg::ST_ADD;
      end
      ewt_pkg::ST_ADD: begin
        load_sum_nxt = load_sum_r + ewt_pkg::SUM_W'(mul_prod);
        if (last_r) begin
          scan_addr_nxt = '0;
          found_nxt     = 1'b0;
          emit_cnt_nxt  = '0;
          state_nxt     = ewt_pkg::ST_SCAN;
        end else begin
          state_nxt = ewt_pkg::ST_IDLE;
        end
      end
      ewt_pkg::ST_SCAN: begin
        rd_valid_nxt = issue;
        if (issue) begin
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
        if (rd_valid_r && !taken_r[rd_idx_r] &&
            (!found_r || (rd_data_r.due_date < best_r.due_date))) begin
          found_nxt    = 1'b1;
          best_idx_nxt = rd_idx_r;
          best_nxt     = rd_data_r;
        end
        if (!issue && !rd_valid_r) begin
          state_nxt = ewt_pkg::ST_TAKE;
        end
      end
      ewt_pkg::ST_TAKE: begin
        taken_nxt[best_idx_r] = 1'b1;
        finish_nxt = finish_r + ewt_pkg::FINISH_W'(best_r.proc_time);
        state_nxt  = ewt_pkg::ST_MUL;
      end
      ewt_pkg::ST_MUL: begin
        edd_add_nxt = 1'b1;
        state_nxt   = ewt_pkg::ST_EMIT;
      end
      ewt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (final_emit) begin
            count_nxt      = '0;
            emit_cnt_nxt   = '0;
            taken_nxt      = '0;
            completion_nxt = '0;
            finish_nxt     = '0;
            load_sum_nxt   = '0;
            edd_sum_nxt    = '0;
            state_nxt      = ewt_pkg::ST_IDLE;
          end else begin
            emit_cnt_nxt  = emit_cnt_r + 1'b1;
            scan_addr_nxt = '0;
            found_nxt     = 1'b0;
            state_nxt     = ewt_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ewt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ewt_pkg::ST_IDLE;
      stored_r     <= 1'b0;
      count_r      <= '0;
      emit_cnt_r   <= '0;
      scan_addr_r  <= '0;
      rd_valid_r   <= 1'b0;
      taken_r      <= '0;
      found_r      <= 1'b0;
      completion_r <= '0;
      finish_r     <= '0;
      load_sum_r   <= '0;
      edd_sum_r    <= '0;
      edd_add_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      stored_r     <= stored_nxt;
      count_r      <= count_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      scan_addr_r  <= scan_addr_nxt;
      rd_valid_r   <= rd_valid_nxt;
      taken_r      <= taken_nxt;
      found_r      <= found_nxt;
      completion_r <= completion_nxt;
      finish_r     <= finish_nxt;
      load_sum_r   <= load_sum_nxt;
      edd_sum_r    <= edd_sum_nxt;
      edd_add_r    <= edd_add_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    rd_idx_r   <= scan_addr_r[ewt_pkg::IDX_W-1:0];
    if (in_fire) begin
      item_r.proc_time <= in_chan.proc_time;
      item_r.weight    <= in_chan.weight;
      item_r.due_date  <= in_chan.due_date;
      last_r           <= in_chan.last_task;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ewt_pkg::ST_STORE) &&
        (count_r < ewt_pkg::CNT_W'(ewt_pkg::MAX_TASKS))) begin
      mem[count_r[ewt_pkg::IDX_W-1:0]] <= item_r;
    end
    rd_data_r <= mem[scan_addr_r[ewt_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index_r <= ewt_pkg::INDEX_W'(best_idx_r);
      out_end_r   <= final_emit;
      out_edd_r   <= final_emit ? edd_total : '0;
      out_load_r  <= final_emit ? load_sum_r : '0;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.task_index         = out_index_r;
  assign out_chan.end_of_order       = out_end_r;
  assign out_chan.edd_penalty        = out_edd_r;
  assign out_chan.load_order_penalty = out_load_r;

endmodule

// ===== test/tb_edd_weighted_tardiness_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_edd_weighted_tardiness_core
// Self-checking testbench of the earliest-due-date ordering core.
// ----------------------------------------------------------------------------
// A short table of directed task sets covers the field extremes, due-date
// ties, zero weights and early completion. Random sets follow: one exactly
// full and one that overflows and closes on a dropped task, then many small
// ones. Every accepted task updates a local model of the core. Every closing
// task queues the expected index order and penalties, and each result item
// is checked against that queue. The sender works in bursts and the
// receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module tb_edd_weighted_tardiness_core;

  localparam int STIM_ROWS    = 22;
  localparam int RANDOM_JOBS  = 128;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic [ewt_pkg::PROC_W-1:0]   proc_time;
    logic [ewt_pkg::WEIGHT_W-1:0] weight;
    logic [ewt_pkg::DUE_W-1:0]    due_date;
    logic                         last_task;
  } job_t;

  typedef struct packed {
    logic [ewt_pkg::INDEX_W-1:0] task_index;
    logic                        end_of_order;
    logic [ewt_pkg::SUM_W-1:0]   edd_penalty;
    logic [ewt_pkg::SUM_W-1:0]   load_order_penalty;
  } order_entry_t;

  typedef struct packed {
    logic [ewt_pkg::PROC_W-1:0]   proc_time;
    logic [ewt_pkg::WEIGHT_W-1:0] weight;
    logic [ewt_pkg::DUE_W-1:0]    due_date;
    logic                         last_task;
    logic                         fixed;
    logic [ewt_pkg::SUM_W-1:0]    fixed_edd;
    logic [ewt_pkg::SUM_W-1:0]    fixed_load;
  } stim_row_t;

  stim_row_t stim_table [STIM_ROWS] = '{
    '{16'd0,     8'd0,   20'd0,       1'b1, 1'b1, 40'd0,        40'd0},
    '{16'd65535, 8'd255, 20'd0,       1'b1, 1'b1, 40'd16711425, 40'd16711425},
    '{16'd65535, 8'd255, 20'd1048575, 1'b1, 1'b1, 40'd0,        40'd0},
    '{16'd1,     8'd255, 20'd0,       1'b1, 1'b1, 40'd255,      40'd255},
    '{16'd5,     8'd3,   20'd100,     1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd7,     8'd2,   20'd100,     1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd4,     8'd1,   20'd50,      1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd9,     8'd4,   20'd100,     1'b1, 1'b0, 40'd0,        40'd0},
    '{16'd100,   8'd10,  20'd1048575, 1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd200,   8'd20,  20'd500,     1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd300,   8'd30,  20'd100,     1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd400,   8'd40,  20'd0,       1'b1, 1'b0, 40'd0,        40'd0},
    '{16'd65535, 8'd0,   20'd0,       1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd65535, 8'd0,   20'd0,       1'b1, 1'b0, 40'd0,        40'd0},
    '{16'd10,    8'd255, 20'd1048575, 1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd10,    8'd255, 20'd1048575, 1'b1, 1'b0, 40'd0,        40'd0},
    '{16'd65535, 8'd255, 20'd0,       1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd65535, 8'd255, 20'd0,       1'b1, 1'b0, 40'd0,        40'd0},
    '{16'd1,     8'd1,   20'd0,       1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd2,     8'd2,   20'd0,       1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd3,     8'd3,   20'd0,       1'b0, 1'b0, 40'd0,        40'd0},
    '{16'd4,     8'd4,   20'd0,       1'b1, 1'b0, 40'd0,        40'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  ewt_in_if  in_chan ();
  ewt_out_if out_chan ();

  edd_weighted_tardiness_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the stored set and the load-order running sums.
  logic [ewt_pkg::PROC_W-1:0]   held_proc   [ewt_pkg::MAX_TASKS];
  logic [ewt_pkg::WEIGHT_W-1:0] held_weight [ewt_pkg::MAX_TASKS];
  logic [ewt_pkg::DUE_W-1:0]    held_due    [ewt_pkg::MAX_TASKS];
  int                           held_count   = 0;
  logic [ewt_pkg::FINISH_W-1:0] load_finish  = '0;
  logic [ewt_pkg::SUM_W-1:0]    load_penalty = '0;

  order_entry_t due_order_q [$];

  int mismatch_count = 0;
  int result_count   = 0;
  int job_count      = 0;
  int set_count      = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int random_jobs    = 0;
  int random_sets    = 0;
  int set_size;
  order_entry_t fixed_entry;

  function automatic logic [ewt_pkg::SUM_W-1:0] lateness_cost(
      input logic [ewt_pkg::FINISH_W-1:0] finish,
      input logic [ewt_pkg::DUE_W-1:0]    due,
      input logic [ewt_pkg::WEIGHT_W-1:0] w);
    logic [ewt_pkg::SUM_W-1:0] late;
    if (finish <= ewt_pkg::FINISH_W'(due)) return '0;
    late = ewt_pkg::SUM_W'(finish - ewt_pkg::FINISH_W'(due));
    return late * ewt_pkg::SUM_W'(w);
  endfunction

  function automatic void order_by_due_date(input job_t j);
    bit                           picked [ewt_pkg::MAX_TASKS];
    int                           best;
    logic [ewt_pkg::FINISH_W-1:0] edd_finish;
    logic [ewt_pkg::SUM_W-1:0]    edd_sum;
    order_entry_t                 entry;
    if (held_count < ewt_pkg::MAX_TASKS) begin
      held_proc[held_count]   = j.proc_time;
      held_weight[held_count] = j.weight;
      held_due[held_count]    = j.due_date;
      load_finish  = load_finish + ewt_pkg::FINISH_W'(j.proc_time);
      load_penalty = load_penalty + lateness_cost(load_finish, j.due_date, j.weight);
      held_count++;
    end
    if (!j.last_task) return;
    foreach (picked[i]) picked[i] = 1'b0;
    edd_finish = '0;
    edd_sum    = '0;
    for (int k = 0; k < held_count; k++) begin
      best = -1;
      for (int i = 0; i < held_count; i++) begin
        if (!picked[i] && (best < 0 || held_due[i] < held_due[best])) best = i;
      end
      picked[best] = 1'b1;
      edd_finish = edd_finish + ewt_pkg::FINISH_W'(held_proc[best]);
      edd_sum    = edd_sum + lateness_cost(edd_finish, held_due[best], held_weight[best]);
      entry.task_index         = ewt_pkg::INDEX_W'(best);
      entry.end_of_order       = (k == held_count - 1);
      entry.edd_penalty        = entry.end_of_order ? edd_sum : '0;
      entry.load_order_penalty = entry.end_of_order ? load_penalty : '0;
      due_order_q = {due_order_q, entry};
    end
    held_count   = 0;
    load_finish  = '0;
    load_penalty = '0;
    set_count++;
  endfunction

  function automatic job_t random_job(input bit closes);
    job_t j;
    case ($urandom_range(0, 2))
      0:       j.proc_time = ewt_pkg::PROC_W'($urandom());
      1:       j.proc_time = ewt_pkg::PROC_W'($urandom_range(0, 60));
      default: j.proc_time = ewt_pkg::PROC_W'($urandom_range(0, 4000));
    endcase
    j.weight = ($urandom_range(0, 7) == 0) ? '0 : ewt_pkg::WEIGHT_W'($urandom());
    case ($urandom_range(0, 3))
      0:       j.due_date = ewt_pkg::DUE_W'($urandom());
      1:       j.due_date = ewt_pkg::DUE_W'($urandom_range(0, 400));
      2:       j.due_date = ewt_pkg::DUE_W'($urandom_range(0, 3) * 100);
      default: j.due_date = ewt_pkg::DUE_W'($urandom_range(0, 20000));
    endcase
    j.last_task = closes;
    return j;
  endfunction

  task automatic send_job(input job_t j);
    @(negedge clk);
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_chan.valid     <= 1'b1;
    in_chan.proc_time <= j.proc_time;
    in_chan.weight    <= j.weight;
    in_chan.due_date  <= j.due_date;
    in_chan.last_task <= j.last_task;
    do @(posedge clk); while (!in_chan.ready);
    burst_left--;
    job_count++;
    order_by_due_date(j);
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, due_order_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    order_entry_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      result_count++;
      if (due_order_q.size() == 0) begin
        $error("result item with no expectation: task_index %0d", out_chan.task_index);
        mismatch_count++;
      end else begin
        want = due_order_q.pop_front();
        if (out_chan.task_index !== want.task_index) begin
          $error("task_index: expected %0d, got %0d", want.task_index, out_chan.task_index);
          mismatch_count++;
        end
        if (out_chan.end_of_order !== want.end_of_order) begin
          $error("end_of_order: expected %0d, got %0d", want.end_of_order,
                 out_chan.end_of_order);
          mismatch_count++;
        end
        if (out_chan.edd_penalty !== want.edd_penalty) begin
          $error("edd_penalty: expected %0d, got %0d", want.edd_penalty,
                 out_chan.edd_penalty);
          mismatch_count++;
        end
        if (out_chan.load_order_penalty !== want.load_order_penalty) begin
          $error("load_order_penalty: expected %0d, got %0d", want.load_order_penalty,
                 out_chan.load_order_penalty);
          mismatch_count++;
        end
      end
    end
  end

  // The receiver picks a new stall pattern after each pass over the bits of stall_bits.
  initial begin
    logic [31:0] stall_bits;
    int          mode;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall_bits = $urandom();
      mode       = $urandom_range(0, 3);
      for (int i = 0; i < 32; i++) begin
        @(negedge clk);
        case (mode)
          0:       out_chan.ready <= 1'b1;
          1:       out_chan.ready <= stall_bits[i];
          2:       out_chan.ready <= (i % 4 == 3);
          default: out_chan.ready <= (i >= 20);
        endcase
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.proc_time <= '0;
    in_chan.weight    <= '0;
    in_chan.due_date  <= '0;
    in_chan.last_task <= 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[r]) begin
      send_job('{stim_table[r].proc_time, stim_table[r].weight,
                 stim_table[r].due_date, stim_table[r].last_task});
      if (stim_table[r].fixed) begin
        fixed_entry = '{ewt_pkg::INDEX_W'(0), 1'b1, stim_table[r].fixed_edd,
                        stim_table[r].fixed_load};
        due_order_q[due_order_q.size() - 1] = fixed_entry;
      end
    end

    while (random_jobs < RANDOM_JOBS) begin
      if (random_sets == 0) begin
        set_size = ewt_pkg::MAX_TASKS;
      end else if (random_sets == 1) begin
        set_size = ewt_pkg::MAX_TASKS + 3;
      end else begin
        set_size = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 16);
      end
      for (int k = 0; k < set_size; k++) send_job(random_job(k == set_size - 1));
      random_jobs += set_size;
      random_sets++;
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (due_order_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d task items in %0d sets, including a full set and an overflowing one",
             job_count, set_count);
    $display("%0d result items checked in %0d cycles", result_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ewt_pkg.sv
rtl/core/ewt_in_if.sv
rtl/core/ewt_out_if.sv
rtl/core/ewt_late_mul.sv
rtl/core/edd_weighted_tardiness_core.sv
test/tb_edd_weighted_tardiness_core.sv
